@@ hdl/mid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mid_pkg
// shared constants for the minimum-image distance core: default coordinate
// width, configuration bus geometry and register indexes
// ----------------------------------------------------------------------------
package mid_pkg;

  // default coordinate width (unsigned fixed point)
  localparam int COORD_BITS_DEF = 24;

  // configuration bus geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd3;

endpackage

@@ hdl/mid_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mid_cfg_regs
// apb register file: periodic mode flag and the three box extents
// ----------------------------------------------------------------------------
module mid_cfg_regs
  import mid_pkg::*;
#(
  parameter int CoordW = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  periodic_o,
  output logic [CoordW-1:0]     ext_x_o,
  output logic [CoordW-1:0]     ext_y_o,
  output logic [CoordW-1:0]     ext_z_o
);

  logic                 periodic_q;
  logic [CoordW-1:0]    ext_x_q;
  logic [CoordW-1:0]    ext_y_q;
  logic [CoordW-1:0]    ext_z_q;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] reg_idx;

  // word addressed, byte lane bits ignored
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b0;
      ext_x_q    <= '1;
      ext_y_q    <= '1;
      ext_z_q    <= '1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PERIODIC: periodic_q <= pwdata[0];
        REG_EXTENT_X: ext_x_q    <= pwdata[CoordW-1:0];
        REG_EXTENT_Y: ext_y_q    <= pwdata[CoordW-1:0];
        REG_EXTENT_Z: ext_z_q    <= pwdata[CoordW-1:0];
        default:      periodic_q <= periodic_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIODIC: prdata = CFG_DATA_W'(periodic_q);
      REG_EXTENT_X: prdata = CFG_DATA_W'(ext_x_q);
      REG_EXTENT_Y: prdata = CFG_DATA_W'(ext_y_q);
      REG_EXTENT_Z: prdata = CFG_DATA_W'(ext_z_q);
      default:      prdata = '0;
    endcase
  end

  assign periodic_o = periodic_q;
  assign ext_x_o    = ext_x_q;
  assign ext_y_o    = ext_y_q;
  assign ext_z_o    = ext_z_q;

  a_periodic_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == REG_PERIODIC) |=> (periodic_q == $past(pwdata[0])))
    else $error("periodic mode write not taken");

endmodule

@@ hdl/mid_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mid_axis
// one axis, three stages: absolute difference, minimum-image fold, square
// ----------------------------------------------------------------------------
module mid_axis
  import mid_pkg::*;
#(
  parameter int CoordW = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CoordW-1:0]     a_i,
  input  logic [CoordW-1:0]     b_i,
  input  logic [CoordW-1:0]     ext_i,
  input  logic                  periodic_i,
  output logic [2*CoordW-1:0]   sq_o
);

  logic [CoordW-1:0]        d_d;
  logic [CoordW-1:0]        d_q;
  logic signed [CoordW:0]   alt;
  logic [CoordW:0]          alt_abs;
  logic                     take;
  logic [CoordW-1:0]        mag_d;
  logic [CoordW-1:0]        mag_q;
  logic [2*CoordW-1:0]      sq_d;
  logic [2*CoordW-1:0]      sq_q;

  // stage 1: |b - a|
  assign d_d = (a_i > b_i) ? (a_i - b_i) : (b_i - a_i);

  // stage 2: in periodic mode, extent - d as signed, keep it if smaller
  assign alt     = $signed({1'b0, ext_i}) - $signed({1'b0, d_q});
  assign take    = periodic_i && (alt < $signed({1'b0, d_q}));
  assign alt_abs = alt[CoordW] ? (~alt + 1'b1) : alt;
  assign mag_d   = take ? alt_abs[CoordW-1:0] : d_q;

  // stage 3: square
  assign sq_d = (2*CoordW)'(mag_q) * (2*CoordW)'(mag_q);

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    mag_q <= mag_d;
    sq_q  <= sq_d;
  end

  assign sq_o = sq_q;

  a_plain_keeps_d : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !periodic_i |=> (mag_q == $past(d_q)))
    else $error("plain mode altered axis distance");

  a_fold_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (mag_q <= $past(d_q)))
    else $error("minimum-image fold grew the axis distance");

endmodule

@@ hdl/mid_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mid_isqrt
// pipelined restoring integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module mid_isqrt
  import mid_pkg::*;
#(
  parameter int SumW  = 2*COORD_BITS_DEF + 2,
  parameter int RootW = COORD_BITS_DEF + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [SumW-1:0]   sum_i,
  output logic              vld_o,
  output logic [RootW-1:0]  root_o
);

  logic [RootW-1:0]             vld_q;
  logic [RootW-1:0][RootW-1:0]  root_q;
  logic [RootW-2:0][SumW-1:0]   rem_q;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;

    logic [SumW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic             vld_in;
    logic [SumW:0]    cand;
    logic             take;
    logic [RootW-1:0] root_d;

    if (k == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (root + 2^bit)^2 - root^2 = root * 2^(bit+1) + 2^(2*bit)
    assign cand   = ((SumW+1)'(root_in) << (Bit + 1)) + ((SumW+1)'(1) << (2 * Bit));
    assign take   = ({1'b0, rem_in} >= cand);
    assign root_d = take ? (root_in | (RootW'(1) << Bit)) : root_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[k] <= root_d;
    end

    if (k < RootW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= take ? (rem_in - cand[SumW-1:0]) : rem_in;
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign root_o = root_q[RootW-1];

endmodule

@@ hdl/min_image_distance_3d_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_image_distance_3d_core
// euclidean distance between two 3d points with optional minimum-image rule
// ----------------------------------------------------------------------------
// Fully pipelined: one point pair may be started every clock cycle (busy is
// never raised) and each pair gives one distance on dist_res_o, flagged by a
// one-cycle done_o strobe. Between start and done_o lie three stages per
// axis (difference, minimum-image fold, square), one stage for the sum and
// the square root, which resolves one result bit per pipeline stage.
// There is no output backpressure: the receiver must take every result in
// the cycle it appears. Coordinates, extents and the result share the same
// unsigned fixed-point format; the distance is the floor of the root of the
// sum of squared per-axis distances. Configuration (periodic mode, box
// extents) is read live by the pipeline, so change it only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module min_image_distance_3d_core
  import mid_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] a_x_i,
  input  logic [COORD_BITS-1:0] a_y_i,
  input  logic [COORD_BITS-1:0] a_z_i,
  input  logic [COORD_BITS-1:0] b_x_i,
  input  logic [COORD_BITS-1:0] b_y_i,
  input  logic [COORD_BITS-1:0] b_z_i,
  // result side
  output logic                  done_o,
  output logic [COORD_BITS:0]   dist_res_o
);

  // sum of three squares needs two extra bits, its root one extra bit
  localparam int SqW    = 2 * COORD_BITS;
  localparam int SumW   = SqW + 2;
  localparam int RootW  = COORD_BITS + 1;
  localparam int AxisSt = 3;

  logic                  periodic;
  logic [COORD_BITS-1:0] ext_x;
  logic [COORD_BITS-1:0] ext_y;
  logic [COORD_BITS-1:0] ext_z;

  logic [SqW-1:0]        sq_x;
  logic [SqW-1:0]        sq_y;
  logic [SqW-1:0]        sq_z;

  logic [AxisSt-1:0]     axis_vld_q;
  logic                  sum_vld_q;
  logic [SumW-1:0]       sum_d;
  logic [SumW-1:0]       sum_q;

  // register file
  mid_cfg_regs #(
    .CoordW (COORD_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .periodic_o (periodic),
    .ext_x_o    (ext_x),
    .ext_y_o    (ext_y),
    .ext_z_o    (ext_z)
  );

  // the pipeline never stalls, a new transaction is taken every cycle
  assign busy = 1'b0;

  // per-axis front end, payload only; valid travels alongside below
  mid_axis #(.CoordW(COORD_BITS)) u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .a_i        (a_x_i),
    .b_i        (b_x_i),
    .ext_i      (ext_x),
    .periodic_i (periodic),
    .sq_o       (sq_x)
  );

  mid_axis #(.CoordW(COORD_BITS)) u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .a_i        (a_y_i),
    .b_i        (b_y_i),
    .ext_i      (ext_y),
    .periodic_i (periodic),
    .sq_o       (sq_y)
  );

  mid_axis #(.CoordW(COORD_BITS)) u_axis_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .a_i        (a_z_i),
    .b_i        (b_z_i),
    .ext_i      (ext_z),
    .periodic_i (periodic),
    .sq_o       (sq_z)
  );

  // sum of squares, one stage
  assign sum_d = SumW'(sq_x) + SumW'(sq_y) + SumW'(sq_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_vld_q <= '0;
      sum_vld_q  <= 1'b0;
    end else begin
      axis_vld_q <= {axis_vld_q[AxisSt-2:0], start};
      sum_vld_q  <= axis_vld_q[AxisSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // root pipeline, its last stage is the output register
  mid_isqrt #(
    .SumW  (SumW),
    .RootW (RootW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sum_vld_q),
    .sum_i  (sum_q),
    .vld_o  (done_o),
    .root_o (dist_res_o)
  );

endmodule
